// File: design/ookrct_pkg.sv
// ----------------------------------------------------------------------------
// OOK remote code transmitter package
// Shared widths, register indexes and protocol constants.
// ----------------------------------------------------------------------------
package ookrct_pkg;

    localparam int CODE_W       = 32;
    localparam int UNIT_W       = 16;
    localparam int TICKS_W      = 21;
    localparam int FRAMES_W     = 8;
    localparam int BITCNT_W     = 6;
    localparam int BITPOS_W     = 5;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 8;
    localparam int S_TDATA_W    = 48;
    localparam int M_TDATA_W    = 8;

    localparam logic [FRAMES_W-1:0] FRAME_REPEATS_RESET  = 8'd15;
    localparam logic [BITCNT_W-1:0] CODE_BIT_COUNT_RESET = 6'd24;
    localparam logic [BITCNT_W-1:0] MAX_CODE_BITS        = 6'd32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FRAME_REPEATS  = 1'b0,
        CFG_CODE_BIT_COUNT = 1'b1
    } cfg_index_t;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_START = 1'b1
    } op_t;

    // Length of one pulse phase in ticks: 1, 3 or 31 units.
    function automatic logic [TICKS_W-1:0] phase_len(
        input logic [CODE_W-1:0]   code,
        input logic [UNIT_W-1:0]   unit,
        input logic                sync,
        input logic [BITPOS_W-1:0] bitpos,
        input logic                low
    );
        logic [TICKS_W-1:0] u1;
        logic [TICKS_W-1:0] u3;
        logic [TICKS_W-1:0] u31;
        logic [TICKS_W-1:0] len;
        u1  = {{(TICKS_W-UNIT_W){1'b0}}, unit};
        u3  = (u1 << 1) + u1;
        u31 = (u1 << 5) - u1;
        if (sync) begin
            len = low ? u31 : u1;
        end else if (code[bitpos]) begin
            len = low ? u1 : u3;
        end else begin
            len = low ? u3 : u1;
        end
        return len;
    endfunction

endpackage

// File: design/ook_rf_remote_code_transmitter.sv
// ----------------------------------------------------------------------------
// OOK RF remote code transmitter
// Pulse-width on-off-keyed encoder: each tick word yields one pin level.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  s_       | in        | tdata: code_word, unit_len; tuser: op
//  m_       | out       | tdata: rf_level, busy_res, start_refused; tlast: done_res
//  cfg_     | in        | index 0 frame_repeats, index 1 code_bit_count
//
// One word is accepted per clock cycle unless the output stalls; its result goes
// to the output register. The transmitter state updates in the same cycle the word
// is accepted. A held output stalls the input side only while m_tready is low.
// Reset is synchronous and returns the block to idle with default registers.
// ----------------------------------------------------------------------------
module ook_rf_remote_code_transmitter (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [ookrct_pkg::S_TDATA_W-1:0]      s_tdata,   // code_word, unit_len
    input  logic                                  s_tuser,   // op
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [ookrct_pkg::M_TDATA_W-1:0]      m_tdata,   // rf_level, busy_res,
                                                             // start_refused, zeros
    output logic                                  m_tlast,   // done_res
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [ookrct_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ookrct_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [ookrct_pkg::FRAMES_W-1:0] frame_repeats_reg;
    logic [ookrct_pkg::BITCNT_W-1:0] code_bit_count_reg;

    logic [ookrct_pkg::CODE_W-1:0]   held_code_reg,   held_code_next;
    logic [ookrct_pkg::UNIT_W-1:0]   held_unit_reg,   held_unit_next;
    logic [ookrct_pkg::FRAMES_W-1:0] frames_left_reg, frames_left_next;
    logic [ookrct_pkg::BITPOS_W-1:0] bit_pos_reg,     bit_pos_next;
    logic                            in_sync_reg,     in_sync_next;
    logic                            phase_reg,       phase_next;
    logic [ookrct_pkg::TICKS_W-1:0]  ticks_reg,       ticks_next;
    logic                            active_reg,      active_next;

    logic                            m_valid_reg;
    logic                            level_reg,   level_next;
    logic                            busy_reg,    busy_next;
    logic                            done_reg,    done_next;
    logic                            refused_reg, refused_next;

    logic                            s_accept;
    logic [ookrct_pkg::CODE_W-1:0]   in_code;
    logic [ookrct_pkg::UNIT_W-1:0]   in_unit;
    logic                            bf_sync;
    logic [ookrct_pkg::BITPOS_W-1:0] bf_pos;
    logic [ookrct_pkg::TICKS_W-1:0]  ticks_dec;

    assign s_tready  = !m_valid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign in_code   = s_tdata[ookrct_pkg::CODE_W-1:0];
    assign in_unit   = s_tdata[ookrct_pkg::CODE_W +: ookrct_pkg::UNIT_W];

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = done_reg;
    assign m_tdata  = {{(ookrct_pkg::M_TDATA_W-3){1'b0}}, refused_reg, busy_reg, level_reg};

    // Frame start: sync only when no code bits, else the top code bit, clamped to bit 31.
    always_comb begin
        bf_sync = (code_bit_count_reg == '0);
        if (bf_sync) begin
            bf_pos = '0;
        end else if (code_bit_count_reg >= ookrct_pkg::MAX_CODE_BITS) begin
            bf_pos = '1;
        end else begin
            bf_pos = code_bit_count_reg[ookrct_pkg::BITPOS_W-1:0] - 1'b1;
        end
    end

    assign ticks_dec = (ticks_reg != '0) ? ticks_reg - 1'b1 : '0;

    always_comb begin
        held_code_next   = held_code_reg;
        held_unit_next   = held_unit_reg;
        frames_left_next = frames_left_reg;
        bit_pos_next     = bit_pos_reg;
        in_sync_next     = in_sync_reg;
        phase_next       = phase_reg;
        ticks_next       = ticks_reg;
        active_next      = active_reg;
        level_next       = 1'b0;
        busy_next        = 1'b0;
        done_next        = 1'b0;
        refused_next     = 1'b0;

        if (s_tuser == ookrct_pkg::OP_START) begin
            if (active_reg || in_unit == '0) begin
                refused_next = 1'b1;
                busy_next    = active_reg;
                level_next   = active_reg && !phase_reg;
            end else begin
                held_code_next   = in_code;
                held_unit_next   = in_unit;
                frames_left_next = (frame_repeats_reg == '0) ? 8'd1 : frame_repeats_reg;
                in_sync_next     = bf_sync;
                bit_pos_next     = bf_pos;
                phase_next       = 1'b0;
                ticks_next       = ookrct_pkg::phase_len(in_code, in_unit, bf_sync,
                                                         bf_pos, 1'b0);
                active_next      = 1'b1;
                busy_next        = 1'b1;
                level_next       = 1'b1;
            end
        end else if (active_reg) begin
            busy_next  = 1'b1;
            level_next = !phase_reg;
            ticks_next = ticks_dec;
            if (ticks_dec == '0) begin
                if (!phase_reg) begin
                    phase_next = 1'b1;
                    ticks_next = ookrct_pkg::phase_len(held_code_reg, held_unit_reg,
                                                       in_sync_reg, bit_pos_reg, 1'b1);
                end else if (!in_sync_reg) begin
                    if (bit_pos_reg == '0) begin
                        in_sync_next = 1'b1;
                    end else begin
                        bit_pos_next = bit_pos_reg - 1'b1;
                    end
                    phase_next = 1'b0;
                    ticks_next = ookrct_pkg::phase_len(held_code_reg, held_unit_reg,
                                                       bit_pos_reg == '0,
                                                       (bit_pos_reg == '0) ? bit_pos_reg
                                                           : bit_pos_reg - 1'b1,
                                                       1'b0);
                end else begin
                    frames_left_next = frames_left_reg - 1'b1;
                    if (frames_left_reg == 8'd1) begin
                        active_next  = 1'b0;
                        done_next    = 1'b1;
                        in_sync_next = 1'b0;
                        phase_next   = 1'b0;
                        bit_pos_next = '0;
                    end else begin
                        in_sync_next = bf_sync;
                        bit_pos_next = bf_pos;
                        phase_next   = 1'b0;
                        ticks_next   = ookrct_pkg::phase_len(held_code_reg, held_unit_reg,
                                                             bf_sync, bf_pos, 1'b0);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_repeats_reg  <= ookrct_pkg::FRAME_REPEATS_RESET;
            code_bit_count_reg <= ookrct_pkg::CODE_BIT_COUNT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                ookrct_pkg::CFG_FRAME_REPEATS: begin
                    frame_repeats_reg <= cfg_data;
                end
                ookrct_pkg::CFG_CODE_BIT_COUNT: begin
                    code_bit_count_reg <= cfg_data[ookrct_pkg::BITCNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frames_left_reg <= '0;
            bit_pos_reg     <= '0;
            in_sync_reg     <= 1'b0;
            phase_reg       <= 1'b0;
            ticks_reg       <= '0;
            active_reg      <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (s_accept) begin
                frames_left_reg <= frames_left_next;
                bit_pos_reg     <= bit_pos_next;
                in_sync_reg     <= in_sync_next;
                phase_reg       <= phase_next;
                ticks_reg       <= ticks_next;
                active_reg      <= active_next;
                m_valid_reg     <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            held_code_reg <= held_code_next;
            held_unit_reg <= held_unit_next;
            level_reg     <= level_next;
            busy_reg      <= busy_next;
            done_reg      <= done_next;
            refused_reg   <= refused_next;
        end
    end

`ifndef SYNTHESIS
    a_done_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[1] && !m_tdata[2])
        else $error("done word without busy or with refusal");

    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        !active_reg |-> !phase_reg && !in_sync_reg)
        else $error("idle transmitter left in a pulse phase");

    a_unit_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> held_unit_reg != '0)
        else $error("active transmission with zero unit length");

    a_hold_output: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_tready |-> !s_tready)
        else $error("input taken while output word is stalled");

    a_frames_live: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> frames_left_reg != '0)
        else $error("active transmission with no frames left");
`endif

endmodule
